### hdl/assert_macros.svh
// Assertion macros for the files that check their own logic.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check an implication or property on every rising clock edge outside reset.
`define AST_PROP(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("property violated");

// Check that a condition never holds outside reset.
`define AST_NEVER(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("forbidden condition seen");

`endif

### hdl/dfce_pkg.sv
// Shared types and codes of the dynamic forest connectivity engine.
package dfce_pkg;

    localparam int ACTION_W = 4;
    localparam int VTX_W    = 6;
    localparam int S_DATA_W = 16;
    localparam int M_DATA_W = 24;
    localparam int SIZE_W   = 7;

    localparam logic [ACTION_W-1:0] ACT_LINK     = 4'd0;
    localparam logic [ACTION_W-1:0] ACT_CUT      = 4'd1;
    localparam logic [ACTION_W-1:0] ACT_CONN     = 4'd2;
    localparam logic [ACTION_W-1:0] ACT_SIZE     = 4'd3;
    localparam logic [ACTION_W-1:0] ACT_ADD_NT   = 4'd4;
    localparam logic [ACTION_W-1:0] ACT_REM_NT   = 4'd5;
    localparam logic [ACTION_W-1:0] ACT_SET_MARK = 4'd6;
    localparam logic [ACTION_W-1:0] ACT_FIND_MK  = 4'd7;
    localparam logic [ACTION_W-1:0] ACT_FIND_NT  = 4'd8;

    typedef enum logic [1:0] {
        KIND_NONE,
        KIND_UPDATE,
        KIND_COMP,
        KIND_FIND
    } kind_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DISPATCH,
        ST_UPD_RD,
        ST_UPD_WR,
        ST_COMP_SEL,
        ST_COMP_FOLD,
        ST_SCAN_SEL,
        ST_SCAN_CHK,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic load;
        logic rd_row;
        logic wr_row;
        logic use_b;
        logic comp_init;
        logic comp_pick;
        logic comp_fold;
        logic scan_init;
        logic scan_pick;
        logic scan_check;
        logic emit;
    } cmd_t;

    typedef struct packed {
        kind_t kind;
        logic  cand_empty;
        logic  hit_any;
        logic  out_full;
    } sts_t;

endpackage

### hdl/dynamic_forest_connectivity_engine.sv
// Top level of the dynamic forest connectivity engine.
//
// The engine holds three symmetric VERTICES x VERTICES bit matrices (tree
// edges, non-tree edges, level marks), each in a RAM of VERTICES rows, with
// one valid bit per row shared by all three, so all matrices read as zero
// right after reset with no clearing pass. One beat in gives one beat out.
// Items run one at a time: an edge update is a dispatch plus a
// read-modify-write of row a and then of row b. A connected or tree size
// query reads the tree row of each tree vertex and folds that row into the
// reach set. A find adds a scan of the tree's rows in ascending vertex
// order, stopping at the first hit. Illegal actions or absent vertices
// return an all-zero result. The next beat is taken as soon as the engine
// is idle, even while the previous result still waits in the output
// register.
module dynamic_forest_connectivity_engine #(
    parameter int VERTICES = 64
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // vertex_a [5:0], vertex_b [11:6], mark_value [12], zero [15:13]
    input  logic [15:0] s_tdata,
    // action [3:0]
    input  logic [3:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // reachable [0], component_size [7:1], edge_found [8],
    // edge_first [14:9], edge_second [20:15], zero [23:21]
    output logic [23:0] m_tdata
);
    import dfce_pkg::*;

`include "assert_macros.svh"

    cmd_t cmd;
    sts_t sts;

    // sequence every item
    dfce_ctrl u_ctrl (
        .aclk(aclk), .aresetn(aresetn), .s_tvalid(s_tvalid), .s_tready(s_tready),
        .sts(sts), .cmd(cmd)
    );

    // hold the matrices and do the row work
    dfce_dp #(.VERTICES(VERTICES)) u_dp (
        .aclk(aclk), .aresetn(aresetn), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tready(m_tready), .m_tvalid(m_tvalid), .m_tdata(m_tdata),
        .cmd(cmd), .sts(sts)
    );

    `AST_PROP(a_busy_after_accept, aclk, aresetn, (s_tvalid && s_tready) |=> !s_tready)
    `AST_PROP(a_emit_shows, aclk, aresetn, cmd.emit |=> m_tvalid)
    `AST_NEVER(a_load_emit, aclk, aresetn, cmd.load && cmd.emit)
    `AST_NEVER(a_rd_wr, aclk, aresetn, cmd.rd_row && cmd.wr_row)
endmodule

### hdl/dfce_ram.sv
// Generic simple dual-port RAM with registered read.
module dfce_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;
endmodule

### hdl/dfce_ctrl.sv
// Controller state machine of the connectivity engine.
module dfce_ctrl (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_tvalid,
    output logic          s_tready,
    input  dfce_pkg::sts_t sts,
    output dfce_pkg::cmd_t cmd
);
    import dfce_pkg::*;

    state_t state_reg, state_next;
    logic   pass_reg, pass_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            pass_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            pass_reg  <= pass_next;
        end
    end

    // next state
    always_comb begin
        state_next = state_reg;
        pass_next  = pass_reg;
        case (state_reg)
            ST_IDLE: begin
                pass_next = 1'b0;
                if (s_tvalid) state_next = ST_DISPATCH;
            end
            ST_DISPATCH: begin
                case (sts.kind)
                    KIND_UPDATE: state_next = ST_UPD_RD;
                    KIND_COMP, KIND_FIND: state_next = ST_COMP_SEL;
                    default: state_next = ST_OUT;
                endcase
            end
            ST_UPD_RD: state_next = ST_UPD_WR;
            ST_UPD_WR: begin
                if (pass_reg) begin
                    state_next = ST_OUT;
                end else begin
                    pass_next  = 1'b1;
                    state_next = ST_UPD_RD;
                end
            end
            ST_COMP_SEL: begin
                if (!sts.cand_empty) state_next = ST_COMP_FOLD;
                else if (sts.kind == KIND_FIND) state_next = ST_SCAN_SEL;
                else state_next = ST_OUT;
            end
            ST_COMP_FOLD: state_next = ST_COMP_SEL;
            ST_SCAN_SEL: begin
                if (sts.cand_empty) state_next = ST_OUT;
                else state_next = ST_SCAN_CHK;
            end
            ST_SCAN_CHK: begin
                if (sts.hit_any) state_next = ST_OUT;
                else state_next = ST_SCAN_SEL;
            end
            ST_OUT: begin
                if (!sts.out_full) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        cmd      = '0;
        s_tready = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                cmd.load = s_tvalid;
            end
            ST_DISPATCH: cmd.comp_init = (sts.kind == KIND_COMP) || (sts.kind == KIND_FIND);
            ST_UPD_RD: begin
                cmd.rd_row = 1'b1;
                cmd.use_b  = pass_reg;
            end
            ST_UPD_WR: begin
                cmd.wr_row = 1'b1;
                cmd.use_b  = pass_reg;
            end
            ST_COMP_SEL: begin
                cmd.comp_pick = !sts.cand_empty;
                cmd.scan_init = sts.cand_empty && (sts.kind == KIND_FIND);
            end
            ST_COMP_FOLD: cmd.comp_fold = 1'b1;
            ST_SCAN_SEL: cmd.scan_pick = !sts.cand_empty;
            ST_SCAN_CHK: cmd.scan_check = 1'b1;
            // hold the new result until the output register is free
            ST_OUT: cmd.emit = !sts.out_full;
            default: cmd = '0;
        endcase
    end
endmodule

### hdl/dfce_dp.sv
// Datapath of the connectivity engine: matrices, reach set, scan and result register.
module dfce_dp #(
    parameter int VERTICES = 64
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic [dfce_pkg::S_DATA_W-1:0]   s_tdata,
    input  logic [dfce_pkg::ACTION_W-1:0]   s_tuser,
    input  logic                            m_tready,
    output logic                            m_tvalid,
    output logic [dfce_pkg::M_DATA_W-1:0]   m_tdata,
    input  dfce_pkg::cmd_t                  cmd,
    output dfce_pkg::sts_t                  sts
);
    import dfce_pkg::*;

    localparam int AW = $clog2(VERTICES);
    localparam int CW = $clog2(VERTICES + 1);
    localparam logic [VERTICES-1:0] ONE = {{(VERTICES-1){1'b0}}, 1'b1};

    logic [ACTION_W-1:0] op_reg;
    logic [AW-1:0]       a_reg, b_reg, pick_reg, x_reg, y_reg;
    logic                mark_reg, a_ok_reg, b_ok_reg, found_reg;
    logic [VERTICES-1:0] vis_reg, done_reg, row_vld_reg;
    logic                rd_vld_reg;
    logic [CW-1:0]       count_reg;
    logic                m_tvalid_reg;
    logic [M_DATA_W-1:0] m_tdata_reg;

    logic [VERTICES-1:0] tree_rd, nt_rd, mk_rd, tr_m, nt_m, mk_m;
    logic [VERTICES-1:0] tree_w, nt_w, mk_w, bitv, cand, hit, gt_mask;
    logic [AW-1:0]       raddr, waddr, col, pick, hit_low;
    logic                pair_ok;
    kind_t               kind;
    logic [M_DATA_W-1:0] result;

    assign pair_ok = a_ok_reg && b_ok_reg;

    always_comb begin
        case (op_reg)
            ACT_LINK, ACT_CUT, ACT_ADD_NT, ACT_REM_NT, ACT_SET_MARK:
                kind = pair_ok ? KIND_UPDATE : KIND_NONE;
            ACT_CONN: kind = pair_ok ? KIND_COMP : KIND_NONE;
            ACT_SIZE: kind = b_ok_reg ? KIND_COMP : KIND_NONE;
            ACT_FIND_MK, ACT_FIND_NT: kind = b_ok_reg ? KIND_FIND : KIND_NONE;
            default: kind = KIND_NONE;
        endcase
    end

    // unwritten rows read as zero
    assign tr_m = rd_vld_reg ? tree_rd : '0;
    assign nt_m = rd_vld_reg ? nt_rd   : '0;
    assign mk_m = rd_vld_reg ? mk_rd   : '0;

    assign cand = vis_reg & ~done_reg;

    always_comb begin
        pick = '0;
        for (int i = VERTICES - 1; i >= 0; i--) begin
            if (cand[i]) pick = AW'(i);
        end
    end

    always_comb begin
        for (int i = 0; i < VERTICES; i++) begin
            gt_mask[i] = (i > int'(pick_reg));
        end
    end

    assign hit = (op_reg == ACT_FIND_MK) ? (tr_m & mk_m & gt_mask) : nt_m;

    always_comb begin
        hit_low = '0;
        for (int i = VERTICES - 1; i >= 0; i--) begin
            if (hit[i]) hit_low = AW'(i);
        end
    end

    // row write: pass on row a writes bit b, pass on row b writes bit a
    assign waddr = cmd.use_b ? b_reg : a_reg;
    assign col   = cmd.use_b ? a_reg : b_reg;
    assign bitv  = ONE << col;
    assign raddr = cmd.rd_row ? waddr : pick;

    always_comb begin
        tree_w = tr_m;
        nt_w   = nt_m;
        mk_w   = mk_m;
        case (op_reg)
            ACT_LINK: tree_w = tr_m | bitv;
            ACT_CUT: begin
                tree_w = tr_m & ~bitv;
                mk_w   = mk_m & ~bitv;
            end
            ACT_ADD_NT: nt_w = nt_m | bitv;
            ACT_REM_NT: nt_w = nt_m & ~bitv;
            ACT_SET_MARK: mk_w = mark_reg ? (mk_m | bitv) : (mk_m & ~bitv);
            default: tree_w = tr_m;
        endcase
    end

    dfce_ram #(.WIDTH(VERTICES), .DEPTH(VERTICES)) u_tree_ram (
        .aclk(aclk), .we(cmd.wr_row), .waddr(waddr), .wdata(tree_w),
        .raddr(raddr), .rdata(tree_rd)
    );
    dfce_ram #(.WIDTH(VERTICES), .DEPTH(VERTICES)) u_nt_ram (
        .aclk(aclk), .we(cmd.wr_row), .waddr(waddr), .wdata(nt_w),
        .raddr(raddr), .rdata(nt_rd)
    );
    dfce_ram #(.WIDTH(VERTICES), .DEPTH(VERTICES)) u_mark_ram (
        .aclk(aclk), .we(cmd.wr_row), .waddr(waddr), .wdata(mk_w),
        .raddr(raddr), .rdata(mk_rd)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_vld_reg <= '0;
        end else if (cmd.wr_row) begin
            row_vld_reg[waddr] <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        rd_vld_reg <= row_vld_reg[raddr];
        if (cmd.load) begin
            op_reg   <= s_tuser;
            a_reg    <= AW'(s_tdata[VTX_W-1:0]);
            b_reg    <= AW'(s_tdata[2*VTX_W-1:VTX_W]);
            mark_reg <= s_tdata[2*VTX_W];
            a_ok_reg <= {3'b000, s_tdata[VTX_W-1:0]} < 9'(VERTICES);
            b_ok_reg <= {3'b000, s_tdata[2*VTX_W-1:VTX_W]} < 9'(VERTICES);
        end
        if (cmd.comp_init) begin
            vis_reg   <= ONE << ((op_reg == ACT_CONN) ? a_reg : b_reg);
            done_reg  <= '0;
            count_reg <= '0;
        end
        if (cmd.comp_pick || cmd.scan_pick) begin
            done_reg[pick] <= 1'b1;
            pick_reg       <= pick;
        end
        if (cmd.comp_pick) count_reg <= CW'(count_reg + 1'b1);
        if (cmd.comp_fold) vis_reg <= vis_reg | tr_m;
        if (cmd.scan_init) begin
            done_reg  <= '0;
            found_reg <= 1'b0;
            x_reg     <= '0;
            y_reg     <= '0;
        end
        if (cmd.scan_check && (|hit)) begin
            found_reg <= 1'b1;
            x_reg     <= pick_reg;
            y_reg     <= hit_low;
        end
    end

    // result fields from bit 0 up: reachable, component_size, edge_found,
    // edge_first, edge_second
    always_comb begin
        result = '0;
        if (kind == KIND_COMP && op_reg == ACT_CONN) result[0] = vis_reg[b_reg];
        if (kind == KIND_COMP && op_reg == ACT_SIZE) result[7:1] = SIZE_W'(count_reg);
        if (kind == KIND_FIND) begin
            result[8]     = found_reg;
            result[14:9]  = VTX_W'(x_reg);
            result[20:15] = VTX_W'(y_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (cmd.emit) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit) m_tdata_reg <= result;
    end

    assign m_tvalid       = m_tvalid_reg;
    assign m_tdata        = m_tdata_reg;
    assign sts.kind       = kind;
    assign sts.cand_empty = ~|cand;
    assign sts.hit_any    = |hit;
    assign sts.out_full   = m_tvalid_reg && !m_tready;
endmodule
